// File: hdl/dwm_pkg.sv
// Shared types and constants of the decimated window median filter.
package dwm_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int INTERVAL_W  = 16;
  localparam int LEN_CFG_W   = 5;
  localparam int FILL_OUT_W  = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION_INTERVAL = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN          = CFG_INDEX_W'(1);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
  localparam int                    LEN_RESET      = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RANK,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    RK_IDLE,
    RK_SCAN,
    RK_LAST
  } rank_state_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] value;
    logic [SAMPLE_W-1:0] stamp;
  } rank_res_t;

endpackage

// File: hdl/decimated_window_median.sv
// Top level of the decimated sliding-window median filter.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------------
//   input    | in_valid / in_stall     | sample_time, sample_value
//   output   | out_valid / out_stall   | accepted, median_value, median_time, fill_level
//   config   | cfg_we                  | cfg_index, cfg_data
//
// The rank walk reads the value memory once per filled entry per candidate, the fill
// level being taken after the update. A search stops early at the first candidate
// whose rank is the median. Synchronous reset empties the window at once. A result
// waits in the output register, and the next input transaction is taken while it
// is stalled.
module decimated_window_median #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dwm_pkg::SAMPLE_W-1:0]     sample_time,
  input  logic signed [dwm_pkg::SAMPLE_W-1:0] sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             accepted,
  output logic signed [dwm_pkg::SAMPLE_W-1:0] median_value,
  output logic [dwm_pkg::SAMPLE_W-1:0]     median_time,
  output logic [dwm_pkg::FILL_OUT_W-1:0]   fill_level,
  input  logic                             cfg_we,
  input  logic [dwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import dwm_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int LEN_INIT = (LEN_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : LEN_RESET;

  top_state_t state, state_next;

  logic [INTERVAL_W-1:0] interval;
  logic [CW-1:0]         len;
  logic [AW-1:0]         write_slot;
  logic [CW-1:0]         fill;
  logic [SAMPLE_W-1:0]   newest;
  logic                  acc_flag;

  logic                  take_in;
  logic                  pass;
  logic [LEN_CFG_W-1:0]  len_cfg;
  logic [CW-1:0]         len_clamped;
  logic [CW:0]           oldest_sum;
  logic [AW-1:0]         oldest;
  logic                  out_free;

  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;
  logic [2*SAMPLE_W-1:0] data_a;
  logic [SAMPLE_W-1:0]   data_b;
  rank_res_t             res;

  assign in_stall = (state != ST_IDLE);
  assign take_in  = in_valid && (state == ST_IDLE);
  assign pass     = ((sample_time - newest) >= SAMPLE_W'(interval));
  assign out_free = !out_valid || !out_stall;

  assign len_cfg     = cfg_data[LEN_CFG_W-1:0];
  assign len_clamped = (len_cfg == '0) ? CW'(1) :
                       ((32'(len_cfg) > WINDOW_DEPTH) ? CW'(WINDOW_DEPTH) : CW'(len_cfg));

  // The oldest entry sits fill places behind the write slot, modulo the length.
  assign oldest_sum = (CW+1)'(write_slot) + (CW+1)'(len) - (CW+1)'(fill);
  assign oldest     = (oldest_sum >= (CW+1)'(len)) ? AW'(oldest_sum - (CW+1)'(len))
                                                   : AW'(oldest_sum);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_START;
      ST_START: state_next = ST_RANK;
      ST_RANK:  if (res.done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      interval   <= INTERVAL_RESET;
      len        <= CW'(LEN_INIT);
      write_slot <= '0;
      fill       <= '0;
      newest     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_DECIMATION_INTERVAL) begin
        interval <= cfg_data[INTERVAL_W-1:0];
      end
      if (cfg_we && cfg_index == REG_WINDOW_LEN) begin
        len        <= len_clamped;
        write_slot <= '0;
        fill       <= '0;
        newest     <= '0;
      end else if (take_in && pass) begin
        write_slot <= (write_slot == AW'(len - CW'(1))) ? '0 : write_slot + AW'(1);
        fill       <= (fill == len) ? fill : fill + CW'(1);
        newest     <= sample_time;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      acc_flag <= pass;
    end
    if (state == ST_OUT && out_free) begin
      accepted     <= acc_flag;
      median_value <= $signed(res.value);
      median_time  <= res.stamp;
      fill_level   <= FILL_OUT_W'(fill);
    end
  end

  dwm_ram #(
    .WIDTH (2*SAMPLE_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ram_entry (
    .clk   (clk),
    .we    (take_in && pass),
    .waddr (write_slot),
    .wdata ({sample_time, sample_value}),
    .raddr (addr_a),
    .rdata (data_a)
  );

  // Second copy of the values so the walk can read another entry in the same cycle.
  dwm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ram_value (
    .clk   (clk),
    .we    (take_in && pass),
    .waddr (write_slot),
    .wdata (sample_value),
    .raddr (addr_b),
    .rdata (data_b)
  );

  dwm_rank #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_START),
    .oldest (oldest),
    .fill   (fill),
    .len    (len),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (data_a),
    .data_b (data_b),
    .res    (res)
  );

endmodule

// File: hdl/dwm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dwm_rank.sv
// Median search: walks the window once per candidate and counts its rank.
module dwm_rank #(
  parameter int WINDOW_DEPTH = 16,
  parameter int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  parameter int CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [AW-1:0]               oldest,
  input  logic [CW-1:0]               fill,
  input  logic [CW-1:0]               len,
  output logic [AW-1:0]               addr_a,
  output logic [AW-1:0]               addr_b,
  input  logic [2*dwm_pkg::SAMPLE_W-1:0] data_a,
  input  logic [dwm_pkg::SAMPLE_W-1:0]   data_b,
  output dwm_pkg::rank_res_t          res
);

  import dwm_pkg::*;

  rank_state_t state, state_next;

  logic [AW-1:0] oldest_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] len_r;
  logic [AW-1:0] ci;
  logic [AW-1:0] cs;
  logic [AW-1:0] j;
  logic [AW-1:0] sj;
  logic [AW-1:0] jd;
  logic [CW-1:0] count;
  logic          cmp_valid;

  logic [SAMPLE_W-1:0] cand_value;
  logic                below;
  logic [CW-1:0]       rank_final;
  logic                scan_end;
  logic                found;

  logic                done_r;
  logic [SAMPLE_W-1:0] value_r;
  logic [SAMPLE_W-1:0] stamp_r;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s,
                                             input logic [CW-1:0] l);
    logic [AW-1:0] last;
    last = AW'(l - CW'(1));
    return (s == last) ? '0 : s + AW'(1);
  endfunction

  assign addr_a     = cs;
  assign addr_b     = sj;
  assign cand_value = data_a[SAMPLE_W-1:0];

  assign res = '{done: done_r, value: value_r, stamp: stamp_r};

  // An entry ranks below the candidate if smaller, or equal and older.
  assign below = ($signed(data_b) < $signed(cand_value)) ||
                 ((data_b == cand_value) && (jd < ci));

  assign rank_final = count + CW'(below);
  assign scan_end   = (CW'(j) == fill_r - CW'(1));
  assign found      = (rank_final == (fill_r >> 1));

  always_comb begin
    state_next = state;
    case (state)
      RK_IDLE: begin
        if (start && (fill != '0)) begin
          state_next = RK_SCAN;
        end
      end
      RK_SCAN: begin
        if (scan_end) begin
          state_next = RK_LAST;
        end
      end
      RK_LAST: begin
        state_next = found ? RK_IDLE : RK_SCAN;
      end
      default: state_next = RK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RK_IDLE;
      cmp_valid <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == RK_SCAN);
      done_r    <= 1'b0;
      if (state == RK_IDLE && start && fill == '0) begin
        done_r <= 1'b1;
      end
      if (state == RK_LAST && found) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      RK_IDLE: begin
        if (start) begin
          oldest_r  <= oldest;
          fill_r    <= fill;
          len_r     <= len;
          ci        <= '0;
          cs        <= oldest;
          j         <= '0;
          sj        <= oldest;
          count     <= '0;
          value_r   <= '0;
          stamp_r   <= '0;
        end
      end
      RK_SCAN: begin
        jd <= j;
        j  <= j + AW'(1);
        sj <= slot_inc(sj, len_r);
        if (cmp_valid) begin
          count <= rank_final;
        end
      end
      RK_LAST: begin
        if (found) begin
          value_r <= data_a[SAMPLE_W-1:0];
          stamp_r <= data_a[2*SAMPLE_W-1:SAMPLE_W];
        end else begin
          ci    <= ci + AW'(1);
          cs    <= slot_inc(cs, len_r);
          j     <= '0;
          sj    <= oldest_r;
          count <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
